/* rtl/ebs_pkg.sv */
// ebs_pkg: shared widths, codes, types and helper functions of the eye blink sequencer.
// Used by ebs_div and eye_blink_sequencer. No dependencies.
package ebs_pkg;

    localparam int unsigned DUR_W     = 16;
    localparam int unsigned CNT_W     = 17;
    localparam int unsigned OPEN_W    = 10;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned RNG_W     = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned KIND_W    = 2;

    // shared divider: 32-bit dividend, 17-bit divisor
    localparam int unsigned DIV_W = 32;
    localparam int unsigned DVS_W = 17;

    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [OPEN_W-1:0] OPEN_FULL = 10'd1000;
    localparam logic [RNG_W-1:0]  DEFAULT_SEED_C = 32'd2463534242;
    localparam logic [RNG_W-1:0]  SEED_RST  = 32'd1;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CLOSING = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CLOSED  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_OPENING = 3'd3;
    localparam logic [PHASE_W-1:0] PH_GAP     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSING  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPENING  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 3'd6;

    // configuration reset values
    localparam logic [DUR_W-1:0] CLOSING_RST  = 16'd90;
    localparam logic [DUR_W-1:0] CLOSED_RST   = 16'd60;
    localparam logic [DUR_W-1:0] OPENING_RST  = 16'd110;
    localparam logic [DUR_W-1:0] GAP_RST      = 16'd120;
    localparam logic [DUR_W-1:0] AUTO_MIN_RST = 16'd2500;
    localparam logic [DUR_W-1:0] AUTO_MAX_RST = 16'd6000;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [DUR_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W+1-DUR_W){1'b0}}, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [RNG_W-1:0] xs32(input logic [RNG_W-1:0] x);
        logic [RNG_W-1:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

/* rtl/ebs_div.sv */
// ebs_div: restoring divider, one quotient bit per cycle, shared by progress and draw.
// Depends on ebs_pkg (t_div_req, t_div_rsp, DIV_W, DVS_W).
module ebs_div
    import ebs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int unsigned CNT_BITS = $clog2(DIV_W);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(DIV_W - 1);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]    r_q, n_q;
    logic [DVS_W-1:0]    r_rem, n_rem;
    logic [DVS_W-1:0]    r_dvs, n_dvs;

    logic [DVS_W:0] w_trial;
    logic           w_ge;

    assign w_trial = {r_rem, r_q[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_q   = {r_q[DIV_W-2:0], w_ge};
            n_rem = w_ge ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

/* rtl/eye_blink_sequencer.sv */
// eye_blink_sequencer: eyelid blink phase sequencer with xorshift32 auto-blink timing.
// A request or a tick that needs no division goes from calc straight to the result
// register; a tick that stays in closing/opening also runs the shared divider, and one that
// fires an auto-blink first draws a new interval through it. One transaction at a time; a
// stalled result register holds the next result back. Reset (synchronous, active low)
// clears state, then runs a draw with ready low, as after a seed write. Depends on ebs_pkg
// and ebs_div.
module eye_blink_sequencer
    import ebs_pkg::*;
#(
    parameter logic [RNG_W-1:0] DEFAULT_SEED = DEFAULT_SEED_C
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_func,
    input  logic [DUR_W-1:0]     i_delta_ms,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic                 i_allowed,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OPEN_W-1:0]    o_openness,
    output logic [PHASE_W-1:0]   o_phase,
    output logic                 o_request_taken,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RNG_W-1:0]     i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CALC = 7'b0000010,
        S_DRAW = 7'b0000100,
        S_PREP = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        M_CLOSE = 2'd0,
        M_OPEN  = 2'd1,
        M_DRAW  = 2'd2
    } t_mode;

    localparam int unsigned PROD_W = CNT_W + OPEN_W;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_emit, n_emit;

    // configuration
    logic [DUR_W-1:0] r_closing, n_closing, r_closed, n_closed;
    logic [DUR_W-1:0] r_opening, n_opening, r_gap, n_gap;
    logic [DUR_W-1:0] r_amin, n_amin, r_amax, n_amax;

    // captured item
    logic              r_func, n_func;
    logic [DUR_W-1:0]  r_delta, n_delta;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic              r_allowed, n_allowed;

    // sequencer state
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CNT_W-1:0]   r_pel, n_pel;
    logic [CNT_W-1:0]   r_ael, n_ael;
    logic [CNT_W-1:0]   r_aint, n_aint;
    logic [RNG_W-1:0]   r_rng, n_rng;
    logic               r_pend, n_pend;
    logic [OPEN_W-1:0]  r_open, n_open;
    logic               r_taken, n_taken;

    // result register
    logic               r_ovalid, n_ovalid;
    logic [OPEN_W-1:0]  r_oopen, n_oopen;
    logic [PHASE_W-1:0] r_ophase, n_ophase;
    logic               r_otaken, n_otaken;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic [CNT_W-1:0]  w_sat_p, w_sat_a;
    logic [PROD_W-1:0] w_prod;
    logic [DUR_W-1:0]  w_span, w_dur;
    logic [DVS_W-1:0]  w_span1;

    assign w_sat_p = sat_add(r_pel, r_delta);
    assign w_sat_a = sat_add(r_ael, r_delta);
    assign w_prod  = {{OPEN_W{1'b0}}, r_pel} * {{CNT_W{1'b0}}, OPEN_FULL};
    assign w_span  = (r_amax >= r_amin) ? DUR_W'(r_amax - r_amin) : '0;
    assign w_span1 = {1'b0, w_span} + DVS_W'(1);
    assign w_dur   = (r_mode == M_CLOSE) ? r_closing : r_opening;

    assign w_req.start    = (r_state == S_PREP);
    assign w_req.dividend = (r_mode == M_DRAW) ? r_rng
                                               : {{(DIV_W-PROD_W){1'b0}}, w_prod};
    assign w_req.divisor  = (r_mode == M_DRAW) ? w_span1 : {1'b0, w_dur};

    ebs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_emit    = r_emit;
        n_closing = r_closing;
        n_closed  = r_closed;
        n_opening = r_opening;
        n_gap     = r_gap;
        n_amin    = r_amin;
        n_amax    = r_amax;
        n_func    = r_func;
        n_delta   = r_delta;
        n_kind    = r_kind;
        n_allowed = r_allowed;
        n_phase   = r_phase;
        n_pel     = r_pel;
        n_ael     = r_ael;
        n_aint    = r_aint;
        n_rng     = r_rng;
        n_pend    = r_pend;
        n_open    = r_open;
        n_taken   = r_taken;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_oopen   = r_oopen;
        n_ophase  = r_ophase;
        n_otaken  = r_otaken;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    case (i_cfg_index)
                        CFG_CLOSING:  n_closing = i_cfg_data[DUR_W-1:0];
                        CFG_CLOSED:   n_closed  = i_cfg_data[DUR_W-1:0];
                        CFG_OPENING:  n_opening = i_cfg_data[DUR_W-1:0];
                        CFG_GAP:      n_gap     = i_cfg_data[DUR_W-1:0];
                        CFG_AUTO_MIN: n_amin    = i_cfg_data[DUR_W-1:0];
                        CFG_AUTO_MAX: n_amax    = i_cfg_data[DUR_W-1:0];
                        CFG_SEED: begin
                            n_rng   = (i_cfg_data != '0) ? i_cfg_data : DEFAULT_SEED;
                            n_emit  = 1'b0;
                            n_state = S_DRAW;
                        end
                        default: ;
                    endcase
                end else if (i_in_valid) begin
                    n_func    = i_func;
                    n_delta   = i_delta_ms;
                    n_kind    = i_kind;
                    n_allowed = i_allowed;
                    n_state   = S_CALC;
                end
            end

            S_CALC: begin
                n_emit  = 1'b1;
                n_taken = 1'b0;
                n_state = S_DONE;
                if (r_func) begin
                    if (r_allowed && r_phase == PH_IDLE &&
                        (r_kind == KIND_SINGLE || r_kind == KIND_DOUBLE)) begin
                        n_phase = PH_CLOSING;
                        n_pel   = '0;
                        n_open  = OPEN_FULL;
                        n_pend  = (r_kind == KIND_DOUBLE);
                        n_taken = 1'b1;
                    end
                end else begin
                    case (r_phase)
                        PH_CLOSING: begin
                            n_pel = w_sat_p;
                            if (w_sat_p >= {1'b0, r_closing}) begin
                                n_phase = PH_CLOSED;
                                n_pel   = '0;
                                n_open  = '0;
                            end else begin
                                n_mode  = M_CLOSE;
                                n_state = S_PREP;
                            end
                        end
                        PH_CLOSED: begin
                            n_pel  = w_sat_p;
                            n_open = '0;
                            if (w_sat_p >= {1'b0, r_closed}) begin
                                n_phase = PH_OPENING;
                                n_pel   = '0;
                            end
                        end
                        PH_OPENING: begin
                            n_pel = w_sat_p;
                            if (w_sat_p >= {1'b0, r_opening}) begin
                                n_open  = OPEN_FULL;
                                n_phase = r_pend ? PH_GAP : PH_IDLE;
                                n_pend  = 1'b0;
                                n_pel   = '0;
                            end else begin
                                n_mode  = M_OPEN;
                                n_state = S_PREP;
                            end
                        end
                        PH_GAP: begin
                            n_pel = w_sat_p;
                            if (w_sat_p >= {1'b0, r_gap}) begin
                                n_phase = PH_CLOSING;
                                n_pel   = '0;
                                n_open  = OPEN_FULL;
                            end
                        end
                        default: begin
                            // idle: count toward the next automatic blink
                            n_phase = PH_IDLE;
                            n_open  = OPEN_FULL;
                            if (r_allowed) begin
                                n_ael = w_sat_a;
                                if (w_sat_a >= r_aint) begin
                                    n_ael   = '0;
                                    n_phase = PH_CLOSING;
                                    n_pel   = '0;
                                    n_state = S_DRAW;
                                end
                            end
                        end
                    endcase
                end
            end

            S_DRAW: begin
                n_rng   = xs32(r_rng);
                n_mode  = M_DRAW;
                n_state = S_PREP;
            end

            S_PREP: begin
                n_state = S_DIV;
            end

            S_DIV: begin
                if (w_rsp.done) begin
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                case (r_mode)
                    M_CLOSE: n_open = OPEN_FULL - w_rsp.quot[OPEN_W-1:0];
                    M_OPEN:  n_open = w_rsp.quot[OPEN_W-1:0];
                    default: n_aint = {1'b0, r_amin} + w_rsp.rem;
                endcase
                n_state = r_emit ? S_DONE : S_IDLE;
            end

            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_oopen  = r_open;
                    n_ophase = r_phase;
                    n_otaken = r_taken;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_DRAW;
            r_mode    <= M_DRAW;
            r_emit    <= 1'b0;
            r_closing <= CLOSING_RST;
            r_closed  <= CLOSED_RST;
            r_opening <= OPENING_RST;
            r_gap     <= GAP_RST;
            r_amin    <= AUTO_MIN_RST;
            r_amax    <= AUTO_MAX_RST;
            r_phase   <= PH_IDLE;
            r_pel     <= '0;
            r_ael     <= '0;
            r_rng     <= SEED_RST;
            r_pend    <= 1'b0;
            r_open    <= OPEN_FULL;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_emit    <= n_emit;
            r_closing <= n_closing;
            r_closed  <= n_closed;
            r_opening <= n_opening;
            r_gap     <= n_gap;
            r_amin    <= n_amin;
            r_amax    <= n_amax;
            r_phase   <= n_phase;
            r_pel     <= n_pel;
            r_ael     <= n_ael;
            r_rng     <= n_rng;
            r_pend    <= n_pend;
            r_open    <= n_open;
            r_ovalid  <= n_ovalid;
        end
        r_func    <= n_func;
        r_delta   <= n_delta;
        r_kind    <= n_kind;
        r_allowed <= n_allowed;
        r_aint    <= n_aint;
        r_taken   <= n_taken;
        r_oopen   <= n_oopen;
        r_ophase  <= n_ophase;
        r_otaken  <= n_otaken;
    end

    assign o_out_valid     = r_ovalid;
    assign o_openness      = r_oopen;
    assign o_phase         = r_ophase;
    assign o_request_taken = r_otaken;

    // openness never exceeds full scale
    a_open_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_openness <= OPEN_FULL))
        else $error("openness above full scale");

    // a taken request always starts closing fully open
    a_taken_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_request_taken) |-> (o_phase == PH_CLOSING && o_openness == OPEN_FULL))
        else $error("taken request did not start a blink");

    // closed phase reports a shut eyelid
    a_closed_shut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_phase == PH_CLOSED) |-> (o_openness == '0))
        else $error("closed phase with open eyelid");

    // an accepted transaction makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accepting a transaction");

    // the divider is only started with a nonzero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> (w_req.divisor != '0))
        else $error("divider started with zero divisor");

endmodule

/* test/tb_eye_blink_sequencer.sv */
// tb_eye_blink_sequencer: self-checking testbench for the eye blink sequencer.
// Drives ticks and blink requests over valid/ready and predicts every result with its own model.
// Depends on ebs_pkg and eye_blink_sequencer.
`timescale 1ns / 100ps

module tb_eye_blink_sequencer;
    import ebs_pkg::*;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_REQ  = 1'b1;
    localparam logic [KIND_W-1:0]    KIND_IGNORED = 2'd2;   // 2 and 3 are ignored kinds
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;

    typedef struct packed {
        logic              func;
        logic [DUR_W-1:0]  delta;
        logic [KIND_W-1:0] kind;
        logic              allowed;
    } t_blink_item;

    typedef struct packed {
        logic [OPEN_W-1:0]  openness;
        logic [PHASE_W-1:0] phase;
        logic               taken;
    } t_lid_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_func = FUNC_TICK;
    logic [DUR_W-1:0]     i_delta_ms = '0;
    logic [KIND_W-1:0]    i_kind = KIND_SINGLE;
    logic                 i_allowed = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [OPEN_W-1:0]    o_openness;
    logic [PHASE_W-1:0]   o_phase;
    logic                 o_request_taken;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_CLOSING;
    logic [RNG_W-1:0]     i_cfg_data = '0;

    eye_blink_sequencer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_delta_ms     (i_delta_ms),
        .i_kind         (i_kind),
        .i_allowed      (i_allowed),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_openness     (o_openness),
        .o_phase        (o_phase),
        .o_request_taken(o_request_taken),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_blink_item item_q[$];
    t_lid_result lid_expect_q[$];
    t_blink_item on_port;
    int unsigned send_idle_pct = 16;
    int unsigned recv_stall_pct = 67;
    int unsigned errors = 0;

    // predicted configuration
    logic [DUR_W-1:0] cfg_closing, cfg_closed, cfg_opening, cfg_gap;
    logic [DUR_W-1:0] cfg_auto_min, cfg_auto_max;
    // predicted state
    logic [PHASE_W-1:0] lid_phase;
    logic [CNT_W-1:0]   lid_elapsed, idle_elapsed, blink_interval;
    logic [RNG_W-1:0]   prng;
    logic               double_pending;
    logic [OPEN_W-1:0]  lid_open;

    function automatic logic [CNT_W-1:0] count_sat(logic [CNT_W-1:0] a, logic [DUR_W-1:0] b);
        logic [31:0] s;
        s = 32'(a) + 32'(b);
        return (s > 32'(CNT_MAX)) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic int unsigned lid_progress(logic [CNT_W-1:0] el, logic [DUR_W-1:0] dur);
        int unsigned p;
        if (dur == 0)
            return OPEN_FULL;
        p = (32'(el) * 32'(OPEN_FULL)) / 32'(dur);
        return (p > OPEN_FULL) ? OPEN_FULL : p;
    endfunction

    function automatic void draw_blink_interval();
        logic [31:0] x;
        logic [31:0] span;
        x = prng;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        prng = x;
        span = (cfg_auto_max >= cfg_auto_min) ? 32'(cfg_auto_max - cfg_auto_min) : 32'd0;
        blink_interval = CNT_W'(32'(cfg_auto_min) + x % (span + 1));
    endfunction

    function automatic void start_closing();
        lid_phase = PH_CLOSING;
        lid_elapsed = '0;
        lid_open = OPEN_FULL;
    endfunction

    function automatic void reset_eyelid();
        cfg_closing = CLOSING_RST;
        cfg_closed = CLOSED_RST;
        cfg_opening = OPENING_RST;
        cfg_gap = GAP_RST;
        cfg_auto_min = AUTO_MIN_RST;
        cfg_auto_max = AUTO_MAX_RST;
        lid_phase = PH_IDLE;
        lid_elapsed = '0;
        idle_elapsed = '0;
        double_pending = 1'b0;
        lid_open = OPEN_FULL;
        prng = SEED_RST;
        draw_blink_interval();
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [RNG_W-1:0] data);
        case (idx)
            CFG_CLOSING:  cfg_closing = data[DUR_W-1:0];
            CFG_CLOSED:   cfg_closed = data[DUR_W-1:0];
            CFG_OPENING:  cfg_opening = data[DUR_W-1:0];
            CFG_GAP:      cfg_gap = data[DUR_W-1:0];
            CFG_AUTO_MIN: cfg_auto_min = data[DUR_W-1:0];
            CFG_AUTO_MAX: cfg_auto_max = data[DUR_W-1:0];
            CFG_SEED: begin
                prng = (data != 0) ? data : DEFAULT_SEED_C;
                draw_blink_interval();   // idle_elapsed is kept
            end
            default: ;
        endcase
    endfunction

    function automatic void tick_eyelid(logic [DUR_W-1:0] d, logic allowed);
        case (lid_phase)
            PH_CLOSING: begin
                lid_elapsed = count_sat(lid_elapsed, d);
                lid_open = OPEN_FULL - OPEN_W'(lid_progress(lid_elapsed, cfg_closing));
                if (lid_elapsed >= cfg_closing) begin
                    lid_phase = PH_CLOSED;
                    lid_elapsed = '0;
                    lid_open = '0;
                end
            end
            PH_CLOSED: begin
                lid_elapsed = count_sat(lid_elapsed, d);
                lid_open = '0;
                if (lid_elapsed >= cfg_closed) begin
                    lid_phase = PH_OPENING;
                    lid_elapsed = '0;
                end
            end
            PH_OPENING: begin
                lid_elapsed = count_sat(lid_elapsed, d);
                lid_open = OPEN_W'(lid_progress(lid_elapsed, cfg_opening));
                if (lid_elapsed >= cfg_opening) begin
                    lid_open = OPEN_FULL;
                    lid_phase = double_pending ? PH_GAP : PH_IDLE;
                    double_pending = 1'b0;
                    lid_elapsed = '0;
                end
            end
            PH_GAP: begin
                lid_elapsed = count_sat(lid_elapsed, d);
                if (lid_elapsed >= cfg_gap)
                    start_closing();
            end
            default: begin
                lid_phase = PH_IDLE;
                lid_open = OPEN_FULL;
                if (allowed) begin
                    idle_elapsed = count_sat(idle_elapsed, d);
                    if (idle_elapsed >= blink_interval) begin
                        idle_elapsed = '0;
                        draw_blink_interval();
                        start_closing();
                    end
                end
            end
        endcase
    endfunction

    function automatic t_lid_result advance_eyelid(t_blink_item it);
        t_lid_result r;
        r.taken = 1'b0;
        if (it.func == FUNC_TICK) begin
            tick_eyelid(it.delta, it.allowed);
        end else if (it.allowed && lid_phase == PH_IDLE &&
                     (it.kind == KIND_SINGLE || it.kind == KIND_DOUBLE)) begin
            start_closing();
            double_pending = (it.kind == KIND_DOUBLE);
            r.taken = 1'b1;
        end
        r.openness = lid_open;
        r.phase = lid_phase;
        return r;
    endfunction

    function automatic t_blink_item mk_tick(logic [DUR_W-1:0] d, logic allowed);
        t_blink_item it;
        it.func = FUNC_TICK;
        it.delta = d;
        it.kind = KIND_SINGLE;
        it.allowed = allowed;
        return it;
    endfunction

    function automatic t_blink_item mk_req(logic [KIND_W-1:0] k, logic allowed);
        t_blink_item it;
        it.func = FUNC_REQ;
        it.delta = DUR_W'($urandom);
        it.kind = k;
        it.allowed = allowed;
        return it;
    endfunction

    // mostly short steps so blinks walk through every phase, some long and extreme ones
    function automatic logic [DUR_W-1:0] rand_delta(int unsigned dscale);
        int unsigned r, hi;
        r = $urandom_range(99);
        hi = (dscale * 8 > 65535) ? 65535 : dscale * 8;
        if (r < 55)
            return DUR_W'($urandom_range(dscale));
        else if (r < 80)
            return DUR_W'($urandom_range(hi));
        else if (r < 95)
            return DUR_W'($urandom_range(65535));
        else
            return r[0] ? '1 : '0;
    endfunction

    function automatic t_blink_item rand_item(int unsigned dscale);
        t_blink_item it;
        int unsigned r;
        it.delta = rand_delta(dscale);
        it.kind = KIND_W'($urandom_range(3));
        if ($urandom_range(99) < 78) begin
            it.func = FUNC_TICK;
            it.allowed = ($urandom_range(99) < 88);
        end else begin
            it.func = FUNC_REQ;
            it.allowed = ($urandom_range(99) < 85);
            r = $urandom_range(19);
            if (r < 9)
                it.kind = KIND_SINGLE;
            else if (r < 18)
                it.kind = KIND_DOUBLE;
            else
                it.kind = KIND_IGNORED | KIND_W'($urandom_range(1));
        end
        return it;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RNG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic write_all(int unsigned closing, int unsigned closed, int unsigned opening,
                             int unsigned gap, int unsigned amin, int unsigned amax,
                             logic [RNG_W-1:0] seed);
        write_reg(CFG_CLOSING, closing);
        write_reg(CFG_CLOSED, closed);
        write_reg(CFG_OPENING, opening);
        write_reg(CFG_GAP, gap);
        write_reg(CFG_AUTO_MIN, amin);
        write_reg(CFG_AUTO_MAX, amax);
        write_reg(CFG_SEED, seed);
    endtask

    task automatic write_random_cfg();
        logic [RNG_W-1:0] seed;
        seed = ($urandom_range(7) == 0) ? '0 : $urandom;
        write_all($urandom_range(300, 1), $urandom_range(200), $urandom_range(300, 1),
                  $urandom_range(200), $urandom_range(300), $urandom_range(600), seed);
    endtask

    // wait until every transaction has come back, then let the block settle;
    // checked on the falling edge so the driver's and monitor's updates have landed
    task automatic drain();
        while (item_q.size() != 0 || i_in_valid || lid_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic run_random(int unsigned n, int unsigned dscale);
        repeat (n) item_q.push_back(rand_item(dscale));
        drain();
    endtask

    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin : drv
        t_blink_item nxt_item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                lid_expect_q.push_back(advance_eyelid(on_port));
            if (!i_in_valid || o_in_ready) begin
                if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt_item = item_q.pop_front();
                    on_port <= nxt_item;
                    i_func <= nxt_item.func;
                    i_delta_ms <= nxt_item.delta;
                    i_kind <= nxt_item.kind;
                    i_allowed <= nxt_item.allowed;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : mon
        t_lid_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lid_expect_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual openness %0d phase %0d",
                         $time, o_openness, o_phase);
                errors++;
            end else begin
                want = lid_expect_q.pop_front();
                check_field("openness", want.openness, o_openness);
                check_field("phase", want.phase, o_phase);
                check_field("request_taken", want.taken, o_request_taken);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("eye_blink_sequencer regression: fail");
        $finish;
    end

    initial begin
        reset_eyelid();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default timing, ignored requests, single and double blink, auto blink
        item_q.push_back(mk_tick(16'd0, 1'b1));
        item_q.push_back(mk_req(KIND_IGNORED, 1'b1));
        item_q.push_back(mk_req(KIND_IGNORED | KIND_DOUBLE, 1'b1));
        item_q.push_back(mk_req(KIND_SINGLE, 1'b0));
        item_q.push_back(mk_req(KIND_SINGLE, 1'b1));
        item_q.push_back(mk_req(KIND_DOUBLE, 1'b1));      // busy, ignored
        item_q.push_back(mk_tick(16'd30, 1'b1));
        item_q.push_back(mk_tick(16'd30, 1'b0));          // running blink ignores allowed
        item_q.push_back(mk_tick(16'd30, 1'b1));
        item_q.push_back(mk_tick(16'd60, 1'b1));
        item_q.push_back(mk_tick(16'd55, 1'b1));
        item_q.push_back(mk_tick(16'd55, 1'b1));
        item_q.push_back(mk_req(KIND_DOUBLE, 1'b1));
        item_q.push_back(mk_tick(16'd100, 1'b1));
        item_q.push_back(mk_tick(16'd60, 1'b1));
        item_q.push_back(mk_tick(16'd200, 1'b1));
        item_q.push_back(mk_tick(16'd120, 1'b0));         // gap ends, second blink starts
        item_q.push_back(mk_tick(16'hFFFF, 1'b0));
        item_q.push_back(mk_tick(16'hFFFF, 1'b0));
        item_q.push_back(mk_tick(16'hFFFF, 1'b0));
        item_q.push_back(mk_tick(16'hFFFF, 1'b0));        // idle, not allowed: no auto count
        item_q.push_back(mk_tick(16'hFFFF, 1'b1));        // auto blink fires
        item_q.push_back(mk_tick(16'hFFFF, 1'b1));
        item_q.push_back(mk_tick(16'hFFFF, 1'b1));
        item_q.push_back(mk_tick(16'hFFFF, 1'b1));
        drain();
        run_random(150, 40);

        // shortest durations, zero closed time and gap, default seed
        write_all(1, 0, 1, 0, 5, 40, '0);
        run_random(220, 4);

        send_idle_pct = 67;
        recv_stall_pct = 16;
        // longest durations, max below min, all-ones seed
        write_all(65535, 65535, 65535, 65535, 65535, 0, '1);
        run_random(120, 16000);

        // zero durations everywhere, plus a write to an unused index
        write_all(0, 0, 0, 0, 0, 0, $urandom);
        write_reg(CFG_UNUSED, $urandom);
        run_random(80, 3);

        write_random_cfg();
        run_random(180, 40);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) begin
            write_random_cfg();
            run_random(160, 40);
        end

        if (errors == 0)
            $display("eye_blink_sequencer regression: pass");
        else
            $display("eye_blink_sequencer regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ebs_pkg.sv
rtl/ebs_div.sv
rtl/eye_blink_sequencer.sv
test/tb_eye_blink_sequencer.sv
